FILE: src/sia_pkg.sv
package sia_pkg;
    localparam int unsigned DataWidthDef = 32;
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;
endpackage

FILE: src/sia_div_stage.sv
// One restoring-division step: quotient bit Step (counted from the top).
module sia_div_stage #(
    parameter int unsigned W    = 32,
    parameter int unsigned Step = 0
) (
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo
);
    localparam int unsigned Bit = W - 1 - Step;
    logic [W:0] trial;
    logic [W:0] diff;
    always_comb begin
        trial = {i_rem, i_quo[Bit]};
        diff  = trial - {1'b0, i_den};
        o_quo = i_quo;
        if (!diff[W]) begin
            o_rem      = diff[W-1:0];
            o_quo[Bit] = 1'b1;
        end else begin
            o_rem = trial[W-1:0];
            o_quo[Bit] = 1'b0;
        end
    end
endmodule

FILE: src/signed_integer_alu_add_sub_mul_div.sv
// Pipeline from accepted input word to output word: decode, ceil(DATA_WIDTH/4) divider stages,
// select, hold, sign fix.
// Throughput: one word per cycle; a stall freezes the whole pipeline.
// The divider runs four restoring steps per stage; the multiplier is a
// registered product of the magnitudes followed by a sign-fix stage.
// Reset (synchronous, active low) clears all stage valid bits.
module signed_integer_alu_add_sub_mul_div #(
    parameter int unsigned DATA_WIDTH = sia_pkg::DataWidthDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] mode, [W+1:2] a, [2W+1:W+2] b, zero fill
    input  logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [W-1:0] result, [W] div_zero, zero fill
    output logic [((DATA_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
    import sia_pkg::*;
    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned Spc   = 4;
    localparam int unsigned Nst   = (W + Spc - 1) / Spc;
    localparam int unsigned Depth = Nst + 4;
    localparam int unsigned OutW  = ((W + 1 + 7) / 8) * 8;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 0: decode and magnitudes
    logic [1:0]   in_mode;
    logic [W-1:0] in_a, in_b;
    assign in_mode = s_axis_tdata[1:0];
    assign in_a    = s_axis_tdata[W+1:2];
    assign in_b    = s_axis_tdata[2*W+1:W+2];

    logic [Depth-1:0] r_vld;
    logic [1:0]   r_mode [Nst+3];
    logic         r_neg  [Nst+3];
    logic         r_dz   [Nst+3];
    logic [W-1:0] r_res  [Nst+3];
    logic [W-1:0] r_rem  [Nst+1];
    logic [W-1:0] r_quo  [Nst+1];
    logic [W-1:0] r_den  [Nst+1];
    logic [W-1:0] r_ma, r_mb;
    logic [W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
    end

    // stage 0 register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mode[0] <= in_mode;
            r_neg[0]  <= in_a[W-1] ^ in_b[W-1];
            r_dz[0]   <= (in_mode == MODE_DIV) && (in_b == '0);
            case (t_mode'(in_mode))
                MODE_ADD: r_res[0] <= in_a + in_b;
                MODE_SUB: r_res[0] <= in_a - in_b;
                default:  r_res[0] <= '1;
            endcase
            r_ma      <= in_a[W-1] ? -in_a : in_a;
            r_mb      <= in_b[W-1] ? -in_b : in_b;
            r_rem[0]  <= '0;
            r_quo[0]  <= in_a[W-1] ? -in_a : in_a;
            r_den[0]  <= in_b[W-1] ? -in_b : in_b;
        end
    end

    // multiplier: one registered product, then carried along
    always_ff @(posedge i_clk) begin
        if (adv) r_prod <= r_ma * r_mb;
    end

    // divider stages
    for (genvar s = 0; s < Nst; s++) begin : g_div
        logic [W-1:0] rem_c [Spc+1];
        logic [W-1:0] quo_c [Spc+1];
        assign rem_c[0] = r_rem[s];
        assign quo_c[0] = r_quo[s];
        for (genvar k = 0; k < Spc; k++) begin : g_step
            if (s*Spc + k < W) begin : g_on
                sia_div_stage #(.W(W), .Step(s*Spc + k)) u_step (
                    .i_rem(rem_c[k]), .i_quo(quo_c[k]), .i_den(r_den[s]),
                    .o_rem(rem_c[k+1]), .o_quo(quo_c[k+1]));
            end else begin : g_off
                assign rem_c[k+1] = rem_c[k];
                assign quo_c[k+1] = quo_c[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem[s+1] <= rem_c[Spc];
                r_quo[s+1] <= quo_c[Spc];
                r_den[s+1] <= r_den[s];
            end
        end
    end

    // side-band carry: stages 1..Nst
    logic [W-1:0] r_prod_d [Nst+1];
    assign r_prod_d[0] = r_prod;
    for (genvar s = 1; s <= Nst; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_mode[s] <= r_mode[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_dz[s]   <= r_dz[s-1];
                r_res[s]  <= r_res[s-1];
            end
        end
        if (s < Nst) begin : g_p
            logic [W-1:0] r_p;
            always_ff @(posedge i_clk) if (adv) r_p <= r_prod_d[s-1];
            assign r_prod_d[s] = r_p;
        end else begin : g_pe
            assign r_prod_d[s] = r_prod_d[s-1];
        end
    end

    // select and hold stages
    logic [W-1:0] sel_mag;
    assign sel_mag = (r_mode[Nst] == MODE_MUL) ? r_prod_d[Nst] : r_quo[Nst];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mode[Nst+1] <= r_mode[Nst];
            r_neg[Nst+1]  <= r_neg[Nst];
            r_dz[Nst+1]   <= r_dz[Nst];
            r_res[Nst+1]  <= sel_mag;
            r_mode[Nst+2] <= r_mode[Nst+1];
            r_neg[Nst+2]  <= r_neg[Nst+1];
            r_dz[Nst+2]   <= r_dz[Nst+1];
            r_res[Nst+2]  <= r_res[Nst+1];
        end
    end

    // output stage: sign fix
    logic [W-1:0] fin;
    logic [W-1:0] r_out;
    logic         r_outdz;
    logic [W-1:0] early;
    assign early = r_res[Nst];
    logic [W-1:0] r_early1, r_early2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_early1 <= early;
            r_early2 <= r_early1;
        end
    end
    always_comb begin
        case (t_mode'(r_mode[Nst+2]))
            MODE_ADD, MODE_SUB: fin = r_early2;
            MODE_MUL: fin = r_neg[Nst+2] ? -r_res[Nst+2] : r_res[Nst+2];
            default:  fin = r_dz[Nst+2] ? '1 :
                            (r_neg[Nst+2] ? -r_res[Nst+2] : r_res[Nst+2]);
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out   <= fin;
            r_outdz <= r_dz[Nst+2];
        end
    end
    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tdata  = OutW'({r_outdz, r_out});
endmodule

FILE: src/sia_checker.sv
module sia_checker #(
    parameter int unsigned W = sia_pkg::DataWidthDef
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((W+1+7)/8)*8-1:0] m_axis_tdata
);
    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // ready follows the output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
    // divide by zero always reads all ones
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[W] |-> m_axis_tdata[W-1:0] == '1)
        else $error("div_zero without all-ones result");
    // no output right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind signed_integer_alu_add_sub_mul_div sia_checker #(.W(DATA_WIDTH)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
